/* hw/rtl/tkd_pkg.sv */
// Shared types and constants for the terminal key escape decoder.
package tkd_pkg;

	localparam int unsigned KIND_W = 2;
	localparam int unsigned CODE_W = 21;

	localparam int unsigned DEF_MAX_PARAM_BYTES = 32;
	localparam int unsigned DEF_VALUE_WIDTH     = 21;

	localparam logic [KIND_W-1:0] KIND_RAW   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_KEY   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PASTE = 2'd2;

	localparam logic [CODE_W-1:0] K_UP     = CODE_W'(0);
	localparam logic [CODE_W-1:0] K_DOWN   = CODE_W'(1);
	localparam logic [CODE_W-1:0] K_LEFT   = CODE_W'(2);
	localparam logic [CODE_W-1:0] K_RIGHT  = CODE_W'(3);
	localparam logic [CODE_W-1:0] K_HOME   = CODE_W'(4);
	localparam logic [CODE_W-1:0] K_END    = CODE_W'(5);
	localparam logic [CODE_W-1:0] K_PGUP   = CODE_W'(6);
	localparam logic [CODE_W-1:0] K_PGDN   = CODE_W'(7);
	localparam logic [CODE_W-1:0] K_DEL    = CODE_W'(8);
	localparam logic [CODE_W-1:0] K_ESC    = CODE_W'(9);
	localparam logic [CODE_W-1:0] K_STAB   = CODE_W'(10);
	localparam logic [CODE_W-1:0] K_SCH    = CODE_W'(11);
	localparam logic [CODE_W-1:0] K_SCL    = CODE_W'(12);
	localparam logic [CODE_W-1:0] K_SCX    = CODE_W'(13);
	localparam logic [CODE_W-1:0] K_PASTE  = CODE_W'(14);

	// ESC [ 2 0 1 ~ , element 0 is the oldest byte
	localparam logic [5:0][7:0] PASTE_END = {8'h7e, 8'h31, 8'h30, 8'h32, 8'h5b, 8'h1b};

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ESC     = 3'd1,
		PH_BRACKET = 3'd2,
		PH_OH      = 3'd3,
		PH_OTHER   = 3'd4,
		PH_PARAMS  = 3'd5,
		PH_PASTE   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CODE_W-1:0] code;
		logic              last;
	} res_t;

endpackage

/* hw/rtl/tkd_if.sv */
// Valid/ready channel interfaces for decoder input events and key results.
interface tkd_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface tkd_out_if;
	logic                        valid;
	logic                        ready;
	logic [tkd_pkg::KIND_W-1:0]  kind;
	logic [tkd_pkg::CODE_W-1:0]  code;
	logic                        last;

	modport source (output valid, output kind, output code, output last, input ready);
	modport sink   (input valid, input kind, input code, input last, output ready);
endinterface

/* hw/rtl/terminal_key_escape_decoder.sv */
// Terminal key escape decoder: turns terminal bytes and wait timeouts into key results.
//
// in_ch carries one event per transfer: mode 0 with a received byte, or mode 1 when
// the caller's wait for the next byte expired. out_ch carries result items (kind,
// code, last); last marks the final result caused by one input event.
// Every input transfer is decoded in the cycle it is taken: parser state updates at
// that edge and its zero, one or two results enter a four-entry result queue, so the
// first result can be taken in the next cycle. One event is accepted per cycle;
// in_ch.ready drops while fewer than two queue entries are free, which only happens
// when the receiver on out_ch stalls.
// Sustained rate is one event per cycle, set by the queue draining one result a cycle.
// Reset (arst_n low) returns the parser to idle, clears the parameter and paste
// state and empties the result queue. While out_ch.ready is low, queued results hold
// and input is taken until the queue can no longer hold a worst-case two results.
module terminal_key_escape_decoder #(
	parameter int unsigned MAX_PARAM_BYTES = tkd_pkg::DEF_MAX_PARAM_BYTES,
	parameter int unsigned VALUE_WIDTH     = tkd_pkg::DEF_VALUE_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	tkd_in_if.sink        in_ch,
	tkd_out_if.source     out_ch
);

	localparam int unsigned VW    = VALUE_WIDTH;
	localparam int unsigned CW    = $clog2(MAX_PARAM_BYTES + 1);
	localparam int unsigned QD    = 4;
	localparam int unsigned QPW   = $clog2(QD);
	localparam int unsigned QCW   = $clog2(QD + 1);

	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_LBR   = 8'h5b;
	localparam logic [7:0] CH_O     = 8'h4f;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_Z     = 8'h5a;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_F     = 8'h46;

	localparam logic [VW-1:0] VMAX = {VW{1'b1}};

	function automatic logic [tkd_pkg::CODE_W-1:0] letter_key(input logic [7:0] b);
		logic [tkd_pkg::CODE_W-1:0] k;
		case (b)
			8'h41:   k = tkd_pkg::K_UP;
			8'h42:   k = tkd_pkg::K_DOWN;
			8'h43:   k = tkd_pkg::K_RIGHT;
			8'h44:   k = tkd_pkg::K_LEFT;
			CH_H:    k = tkd_pkg::K_HOME;
			CH_F:    k = tkd_pkg::K_END;
			default: k = tkd_pkg::K_ESC;
		endcase
		return k;
	endfunction

	function automatic tkd_pkg::res_t key_res(input logic [tkd_pkg::CODE_W-1:0] k);
		tkd_pkg::res_t r;
		r.kind = tkd_pkg::KIND_KEY;
		r.code = k;
		r.last = 1'b1;
		return r;
	endfunction

	// ctrl and ctrl+shift folding of a (modifier, key) pair
	function automatic tkd_pkg::res_t fold_key(input logic [VW-1:0] md, input logic [VW-1:0] key);
		tkd_pkg::res_t r;
		logic [VW-1:0] lower;
		lower = key;
		if (key >= VW'(65) && key <= VW'(90))
			lower = key + VW'(32);
		r.last = 1'b1;
		r.kind = tkd_pkg::KIND_RAW;
		r.code = tkd_pkg::CODE_W'(key);
		if (md == VW'(6) && lower == VW'(104)) begin
			r.kind = tkd_pkg::KIND_KEY;
			r.code = tkd_pkg::K_SCH;
		end else if (md == VW'(6) && lower == VW'(108)) begin
			r.kind = tkd_pkg::KIND_KEY;
			r.code = tkd_pkg::K_SCL;
		end else if (md == VW'(6) && lower == VW'(120)) begin
			r.kind = tkd_pkg::KIND_KEY;
			r.code = tkd_pkg::K_SCX;
		end else if (md == VW'(5) && lower >= VW'(97) && lower <= VW'(122)) begin
			r.code = tkd_pkg::CODE_W'(lower - VW'(96));
		end
		return r;
	endfunction

	tkd_pkg::phase_t   phase_q, phase_d;
	logic [CW-1:0]     pcnt_q, pcnt_d;
	logic [2:0]        ptot_q, ptot_d;
	logic [2:0][VW-1:0] pval_q, pval_d;
	logic [5:0][7:0]   win_q, win_d;
	logic [2:0]        fill_q, fill_d;

	tkd_pkg::res_t     res0, res1;
	logic [1:0]        push_n;

	tkd_pkg::res_t     queue_q [QD];
	logic [QPW-1:0]    wptr_q, rptr_q;
	logic [QCW-1:0]    cnt_q;

	logic              acc, pop;
	logic [7:0]        b;
	logic [VW+3:0]     prod;
	logic [VW-1:0]     cur;
	logic [VW-1:0]     v0;
	logic              is_digit;
	logic [1:0]        tok_sel;

	assign acc = in_ch.valid & in_ch.ready;
	assign pop = out_ch.valid & out_ch.ready;
	assign b   = in_ch.data_byte;
	assign v0  = pval_q[0];
	assign is_digit = b inside {[CH_0:CH_9]};
	assign tok_sel  = 2'(ptot_q - 3'd1);

	always_comb begin
		case (ptot_q)
			3'd1:    cur = pval_q[0];
			3'd2:    cur = pval_q[1];
			3'd3:    cur = pval_q[2];
			default: cur = '0;
		endcase
		prod = ({4'b0, cur} << 3) + ({4'b0, cur} << 1) + (VW+4)'(b - CH_0);
	end

	always_comb begin
		phase_d = phase_q;
		pcnt_d  = pcnt_q;
		ptot_d  = ptot_q;
		pval_d  = pval_q;
		win_d   = win_q;
		fill_d  = fill_q;
		push_n  = 2'd0;
		res0    = '0;
		res1    = '0;
		if (acc) begin
			if (in_ch.mode) begin
				if (phase_q inside {tkd_pkg::PH_ESC, tkd_pkg::PH_BRACKET, tkd_pkg::PH_OH,
						tkd_pkg::PH_OTHER, tkd_pkg::PH_PARAMS}) begin
					phase_d = tkd_pkg::PH_IDLE;
					pcnt_d  = '0;
					ptot_d  = '0;
					pval_d  = '0;
					push_n  = 2'd1;
					res0    = key_res(tkd_pkg::K_ESC);
				end
			end else begin
				case (phase_q)
					tkd_pkg::PH_ESC: begin
						if (b == CH_LBR)
							phase_d = tkd_pkg::PH_BRACKET;
						else if (b == CH_O)
							phase_d = tkd_pkg::PH_OH;
						else
							phase_d = tkd_pkg::PH_OTHER;
					end
					tkd_pkg::PH_BRACKET: begin
						if (is_digit) begin
							pcnt_d    = '0;
							ptot_d    = 3'd1;
							pval_d    = '0;
							pval_d[0] = VW'(b - CH_0);
							phase_d   = tkd_pkg::PH_PARAMS;
						end else begin
							phase_d = tkd_pkg::PH_IDLE;
							push_n  = 2'd1;
							res0    = key_res((b == CH_Z) ? tkd_pkg::K_STAB : letter_key(b));
						end
					end
					tkd_pkg::PH_OH: begin
						phase_d = tkd_pkg::PH_IDLE;
						push_n  = 2'd1;
						res0    = key_res((b == CH_H) ? tkd_pkg::K_HOME :
						                  (b == CH_F) ? tkd_pkg::K_END : tkd_pkg::K_ESC);
					end
					tkd_pkg::PH_OTHER: begin
						phase_d = tkd_pkg::PH_IDLE;
						push_n  = 2'd1;
						res0    = key_res(tkd_pkg::K_ESC);
					end
					tkd_pkg::PH_PARAMS: begin
						if (is_digit || b == CH_SEMI || b == CH_COLON) begin
							if (!is_digit) begin
								if (ptot_q != 3'd7)
									ptot_d = ptot_q + 3'd1;
							end else if (ptot_q >= 3'd1 && ptot_q <= 3'd3) begin
								pval_d[tok_sel] = (prod[VW+3:VW] != 4'd0) ? VMAX
								                                          : prod[VW-1:0];
							end
							pcnt_d = pcnt_q + CW'(1);
							if (pcnt_d >= CW'(MAX_PARAM_BYTES)) begin
								phase_d = tkd_pkg::PH_IDLE;
								pcnt_d  = '0;
								ptot_d  = '0;
								pval_d  = '0;
								push_n  = 2'd1;
								res0    = key_res(tkd_pkg::K_ESC);
							end
						end else begin
							phase_d = tkd_pkg::PH_IDLE;
							pcnt_d  = '0;
							ptot_d  = '0;
							pval_d  = '0;
							push_n  = 2'd1;
							if (b == CH_TILDE) begin
								if (v0 == VW'(200)) begin
									phase_d = tkd_pkg::PH_PASTE;
									fill_d  = '0;
									win_d   = '0;
									push_n  = 2'd0;
								end else if (v0 == VW'(201)) begin
									res0 = key_res(tkd_pkg::K_ESC);
								end else if (ptot_q == 3'd3 && v0 == VW'(27)) begin
									res0 = fold_key(pval_q[1], pval_q[2]);
								end else if (v0 == VW'(1) || v0 == VW'(7)) begin
									res0 = key_res(tkd_pkg::K_HOME);
								end else if (v0 == VW'(3)) begin
									res0 = key_res(tkd_pkg::K_DEL);
								end else if (v0 == VW'(4) || v0 == VW'(8)) begin
									res0 = key_res(tkd_pkg::K_END);
								end else if (v0 == VW'(5)) begin
									res0 = key_res(tkd_pkg::K_PGUP);
								end else if (v0 == VW'(6)) begin
									res0 = key_res(tkd_pkg::K_PGDN);
								end else begin
									res0 = key_res(tkd_pkg::K_ESC);
								end
							end else if (b == CH_U) begin
								res0 = fold_key((ptot_q >= 3'd2) ? pval_q[1] : VW'(1), v0);
							end else if (b == CH_Z) begin
								res0 = key_res(tkd_pkg::K_STAB);
							end else begin
								res0 = key_res(letter_key(b));
							end
						end
					end
					tkd_pkg::PH_PASTE: begin
						if (fill_q >= 3'd6) begin
							push_n    = 2'd1;
							res0.kind = tkd_pkg::KIND_PASTE;
							res0.code = tkd_pkg::CODE_W'(win_q[0]);
							res0.last = 1'b1;
							win_d     = {b, win_q[5:1]};
							fill_d    = 3'd6;
						end else begin
							win_d[fill_q] = b;
							fill_d        = fill_q + 3'd1;
						end
						if (fill_d == 3'd6 && win_d == tkd_pkg::PASTE_END) begin
							phase_d = tkd_pkg::PH_IDLE;
							fill_d  = '0;
							win_d   = '0;
							if (push_n == 2'd1) begin
								res0.last = 1'b0;
								res1      = key_res(tkd_pkg::K_PASTE);
								push_n    = 2'd2;
							end else begin
								res0   = key_res(tkd_pkg::K_PASTE);
								push_n = 2'd1;
							end
						end
					end
					default: begin
						if (b == CH_ESC) begin
							phase_d = tkd_pkg::PH_ESC;
						end else begin
							phase_d   = tkd_pkg::PH_IDLE;
							push_n    = 2'd1;
							res0.kind = tkd_pkg::KIND_RAW;
							res0.code = tkd_pkg::CODE_W'(b);
							res0.last = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tkd_pkg::PH_IDLE;
			pcnt_q  <= '0;
			ptot_q  <= '0;
			pval_q  <= '0;
			win_q   <= '0;
			fill_q  <= '0;
		end else begin
			phase_q <= phase_d;
			pcnt_q  <= pcnt_d;
			ptot_q  <= ptot_d;
			pval_q  <= pval_d;
			win_q   <= win_d;
			fill_q  <= fill_d;
		end
	end

	// result queue
	assign in_ch.ready = (cnt_q <= QCW'(QD - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			queue_q[wptr_q] <= res0;
		if (push_n == 2'd2)
			queue_q[wptr_q + QPW'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + QPW'(push_n);
			if (pop)
				rptr_q <= rptr_q + QPW'(1);
			cnt_q <= cnt_q + QCW'(push_n) - QCW'(pop);
		end
	end

	assign out_ch.valid = (cnt_q != '0);
	assign out_ch.kind  = queue_q[rptr_q].kind;
	assign out_ch.code  = queue_q[rptr_q].code;
	assign out_ch.last  = queue_q[rptr_q].last;

endmodule

/* bench/tkd_decode_checker.sv */
// Watches the decoder channels, predicts every key result and compares it with the block.
module tkd_decode_checker (
	input  logic clk,
	input  logic arst_n,
	tkd_in_if    in_ch,
	tkd_out_if   out_ch,
	output int   fails,
	output int   due_count,
	output int   events_seen,
	output int   results_seen,
	output int   pastes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_BYTES = tkd_pkg::DEF_MAX_PARAM_BYTES;
	localparam logic [63:0] VALUE_MAX = (64'd1 << tkd_pkg::DEF_VALUE_WIDTH) - 64'd1;
	localparam logic [7:0]  ESC_BYTE = 8'h1b;

	tkd_pkg::phase_t phase;
	int unsigned param_bytes;
	int unsigned token_count;
	logic [63:0] token_val [3];
	logic [7:0]  tail_win [6];
	int unsigned tail_fill;

	tkd_pkg::res_t step_keys[$];
	tkd_pkg::res_t keys_due[$];
	tkd_pkg::res_t want;

	function automatic void clear_tokens();
		param_bytes = 0;
		token_count = 0;
		foreach (token_val[i]) token_val[i] = 64'd0;
	endfunction

	function automatic void clear_tail();
		tail_fill = 0;
		foreach (tail_win[i]) tail_win[i] = 8'h00;
	endfunction

	function automatic void reset_decoder();
		phase = tkd_pkg::PH_IDLE;
		clear_tokens();
		clear_tail();
	endfunction

	function automatic void add_key(input logic [tkd_pkg::KIND_W-1:0] k, input logic [63:0] c);
		tkd_pkg::res_t r;
		r.kind = k;
		r.code = c[tkd_pkg::CODE_W-1:0];
		r.last = 1'b0;
		step_keys.insert(step_keys.size(), r);
	endfunction

	function automatic logic [tkd_pkg::CODE_W-1:0] letter_to_key(input logic [7:0] b);
		case (b)
		"A": return tkd_pkg::K_UP;
		"B": return tkd_pkg::K_DOWN;
		"C": return tkd_pkg::K_RIGHT;
		"D": return tkd_pkg::K_LEFT;
		"H": return tkd_pkg::K_HOME;
		"F": return tkd_pkg::K_END;
		default: return tkd_pkg::K_ESC;
		endcase
	endfunction

	// ctrl folds letters to control codes, ctrl+shift picks the three named chords
	function automatic logic [63:0] fold_key(input logic [63:0] modv, input logic [63:0] key,
			output logic [tkd_pkg::KIND_W-1:0] k);
		logic [63:0] lower;
		lower = key;
		if (key >= "A" && key <= "Z")
			lower = key + 64'd32;
		if (modv == 64'd6) begin
			k = tkd_pkg::KIND_KEY;
			if (lower == "h") return 64'(tkd_pkg::K_SCH);
			if (lower == "l") return 64'(tkd_pkg::K_SCL);
			if (lower == "x") return 64'(tkd_pkg::K_SCX);
		end
		k = tkd_pkg::KIND_RAW;
		if (modv == 64'd5 && lower >= "a" && lower <= "z")
			return lower - 64'("a") + 64'd1;
		return key;
	endfunction

	function automatic void end_csi(input logic [7:0] fb);
		logic [63:0]                v0;
		logic [tkd_pkg::KIND_W-1:0] k;
		logic [63:0]                c;
		v0 = token_val[0];
		k = tkd_pkg::KIND_KEY;
		c = 64'(tkd_pkg::K_ESC);
		phase = tkd_pkg::PH_IDLE;
		if (fb == "~") begin
			if (v0 == 64'd200) begin
				phase = tkd_pkg::PH_PASTE;
				clear_tail();
				clear_tokens();
				return;
			end
			if (v0 == 64'd201)
				c = 64'(tkd_pkg::K_ESC);
			else if (token_count == 3 && v0 == 64'd27)
				c = fold_key(token_val[1], token_val[2], k);
			else begin
				case (v0)
				64'd1, 64'd7: c = 64'(tkd_pkg::K_HOME);
				64'd3: c = 64'(tkd_pkg::K_DEL);
				64'd4, 64'd8: c = 64'(tkd_pkg::K_END);
				64'd5: c = 64'(tkd_pkg::K_PGUP);
				64'd6: c = 64'(tkd_pkg::K_PGDN);
				default: c = 64'(tkd_pkg::K_ESC);
				endcase
			end
		end else if (fb == "u") begin
			c = fold_key(token_count >= 2 ? token_val[1] : 64'd1, v0, k);
		end else if (fb == "Z") begin
			c = 64'(tkd_pkg::K_STAB);
		end else begin
			c = 64'(letter_to_key(fb));
		end
		clear_tokens();
		add_key(k, c);
	endfunction

	function automatic void decode_event(input logic tmo, input logic [7:0] b);
		logic [63:0] v;
		logic        hit;
		step_keys.delete();
		if (tmo) begin
			if (phase != tkd_pkg::PH_IDLE && phase != tkd_pkg::PH_PASTE) begin
				phase = tkd_pkg::PH_IDLE;
				clear_tokens();
				add_key(tkd_pkg::KIND_KEY, 64'(tkd_pkg::K_ESC));
			end
		end else begin
			case (phase)
			tkd_pkg::PH_IDLE: begin
				if (b == ESC_BYTE)
					phase = tkd_pkg::PH_ESC;
				else
					add_key(tkd_pkg::KIND_RAW, 64'(b));
			end
			tkd_pkg::PH_ESC: begin
				phase = (b == "[") ? tkd_pkg::PH_BRACKET :
				        (b == "O") ? tkd_pkg::PH_OH : tkd_pkg::PH_OTHER;
			end
			tkd_pkg::PH_BRACKET: begin
				if (b >= "0" && b <= "9") begin
					clear_tokens();
					token_count = 1;
					token_val[0] = 64'(b - 8'h30);
					phase = tkd_pkg::PH_PARAMS;
				end else begin
					phase = tkd_pkg::PH_IDLE;
					add_key(tkd_pkg::KIND_KEY,
						64'((b == "Z") ? tkd_pkg::K_STAB : letter_to_key(b)));
				end
			end
			tkd_pkg::PH_OH: begin
				phase = tkd_pkg::PH_IDLE;
				add_key(tkd_pkg::KIND_KEY, 64'((b == "H") ? tkd_pkg::K_HOME :
					(b == "F") ? tkd_pkg::K_END : tkd_pkg::K_ESC));
			end
			tkd_pkg::PH_OTHER: begin
				phase = tkd_pkg::PH_IDLE;
				add_key(tkd_pkg::KIND_KEY, 64'(tkd_pkg::K_ESC));
			end
			tkd_pkg::PH_PARAMS: begin
				if ((b >= "0" && b <= "9") || b == ";" || b == ":") begin
					if (b == ";" || b == ":") begin
						if (token_count < 7)
							token_count++;
					end else if (token_count >= 1 && token_count <= 3) begin
						v = token_val[token_count-1] * 64'd10 + 64'(b - 8'h30);
						token_val[token_count-1] = (v > VALUE_MAX) ? VALUE_MAX : v;
					end
					param_bytes++;
					if (param_bytes >= MAX_BYTES) begin
						phase = tkd_pkg::PH_IDLE;
						clear_tokens();
						add_key(tkd_pkg::KIND_KEY, 64'(tkd_pkg::K_ESC));
					end
				end else begin
					end_csi(b);
				end
			end
			tkd_pkg::PH_PASTE: begin
				if (tail_fill >= 6) begin
					add_key(tkd_pkg::KIND_PASTE, 64'(tail_win[0]));
					for (int i = 0; i < 5; i++)
						tail_win[i] = tail_win[i+1];
					tail_win[5] = b;
					tail_fill = 6;
				end else begin
					tail_win[tail_fill] = b;
					tail_fill++;
				end
				hit = (tail_fill == 6);
				for (int i = 0; i < 6; i++)
					if (tail_win[i] != tkd_pkg::PASTE_END[i])
						hit = 1'b0;
				if (hit) begin
					add_key(tkd_pkg::KIND_KEY, 64'(tkd_pkg::K_PASTE));
					phase = tkd_pkg::PH_IDLE;
					clear_tail();
				end
			end
			default: begin
				phase = tkd_pkg::PH_IDLE;
			end
			endcase
		end
		if (step_keys.size() != 0)
			step_keys[step_keys.size()-1].last = 1'b1;
		foreach (step_keys[i])
			keys_due.insert(keys_due.size(), step_keys[i]);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			reset_decoder();
			keys_due.delete();
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				decode_event(in_ch.mode, in_ch.data_byte);
				events_seen++;
			end
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (keys_due.size() == 0) begin
					$error("result with nothing due: kind %0d code %0d last %0d",
						out_ch.kind, out_ch.code, out_ch.last);
					fails++;
				end else begin
					want = keys_due[0];
					keys_due.delete(0);
					if (want.kind == tkd_pkg::KIND_KEY && want.code == tkd_pkg::K_PASTE)
						pastes_seen++;
					if (out_ch.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
						fails++;
					end
					if (out_ch.code !== want.code) begin
						$error("code: expected %0d, got %0d", want.code, out_ch.code);
						fails++;
					end
					if (out_ch.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_ch.last);
						fails++;
					end
				end
			end
		end
		due_count = keys_due.size();
	end

endmodule

/* bench/tb_terminal_key_escape_decoder.sv */
// Top of the decoder testbench: clock, reset, byte and timeout stimulus, verdict.
module tb_terminal_key_escape_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned ITEM_TARGET = 1140;
	localparam logic [7:0]  ESC_BYTE = 8'h1b;

	logic clk = 1'b0;
	logic arst_n;

	tkd_in_if  in_ch ();
	tkd_out_if out_ch ();

	int fails, due_count, events_seen, results_seen, pastes_seen;
	int unsigned bytes_sent = 0;
	int unsigned timeouts_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned rx_wait = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	terminal_key_escape_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	tkd_decode_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.fails        (fails),
		.due_count    (due_count),
		.events_seen  (events_seen),
		.results_seen (results_seen),
		.pastes_seen  (pastes_seen)
	);

	always #4 clk = ~clk;

	// receiver: stall drawn after every result transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_wait = 0;
			out_ch.ready <= 1'b0;
		end else if (out_ch.valid && out_ch.ready) begin
			rx_wait = rx_steady ? 0 : $urandom_range(0, 13);
			out_ch.ready <= (rx_wait == 0);
		end else if (!out_ch.ready) begin
			if (rx_wait != 0)
				rx_wait--;
			out_ch.ready <= (rx_wait == 0);
		end
	end

	task automatic put_event(input logic m, input logic [7:0] b);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if ($urandom_range(0, 39) == 0) begin
			tx_steady = ($urandom_range(0, 2) == 0);
			rx_steady = ($urandom_range(0, 2) == 0);
		end
	endtask

	task automatic put_byte(input logic [7:0] b);
		put_event(1'b0, b);
		bytes_sent++;
	endtask

	task automatic put_timeout();
		put_event(1'b1, 8'($urandom_range(0, 255)));
		timeouts_sent++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_number(input longint unsigned n);
		put_text($sformatf("%0d", n));
	endtask

	task automatic put_csi_intro();
		put_byte(ESC_BYTE);
		put_byte("[");
	endtask

	function automatic longint unsigned pick_value();
		case ($urandom_range(0, 5))
		0: return $urandom_range(0, 9);
		1: return $urandom_range(0, 999);
		2: return $urandom_range(0, 32'h10ffff);
		3: return {$urandom, $urandom};
		default: return $urandom_range(0, 300);
		endcase
	endfunction

	function automatic longint unsigned pick_key();
		string letters;
		letters = "AZazhlxHLXmq";
		case ($urandom_range(0, 3))
		0: return letters[$urandom_range(0, letters.len() - 1)];
		1: return $urandom_range("a", "z");
		2: return $urandom_range("A", "Z");
		default: return pick_value();
		endcase
	endfunction

	function automatic longint unsigned pick_mod();
		case ($urandom_range(0, 4))
		0, 1: return 5;
		2: return 6;
		3: return 1;
		default: return $urandom_range(0, 9);
		endcase
	endfunction

	function automatic logic [7:0] pick_sep();
		return ($urandom_range(0, 3) == 0) ? ":" : ";";
	endfunction

	task automatic put_tokens(input int unsigned ntok);
		for (int t = 0; t < ntok; t++) begin
			if (t != 0)
				put_byte(pick_sep());
			if (t == 0 || $urandom_range(0, 5) != 0)
				put_number(pick_value());
		end
	endtask

	task automatic put_paste();
		int unsigned len;
		int unsigned cut;
		string tail;
		tail = "[201~";
		put_csi_intro();
		if ($urandom_range(0, 7) == 0)
			put_text("200;5~");
		else
			put_text("200~");
		len = $urandom_range(0, 14);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 15))
			0, 1: put_byte(ESC_BYTE);
			2: begin
				cut = $urandom_range(0, 3);
				put_byte(ESC_BYTE);
				for (int j = 0; j <= cut; j++)
					put_byte(tail[j]);
			end
			3: put_timeout();
			default: put_byte(8'($urandom_range(0, 255)));
			endcase
		end
		if ($urandom_range(0, 9) != 0) begin
			put_byte(ESC_BYTE);
			put_text(tail);
		end
	endtask

	task automatic play_random();
		string finals;
		int unsigned n;
		finals = "ABCDHFZ~uqa@";
		case ($urandom_range(0, 17))
		0: put_byte(8'($urandom_range(0, 255)));
		1: put_timeout();
		2: begin
			put_csi_intro();
			if ($urandom_range(0, 3) == 0)
				put_byte(8'($urandom_range(0, 255)));
			else
				put_byte(finals[$urandom_range(0, 6)]);
		end
		3: begin
			put_byte(ESC_BYTE);
			put_byte("O");
			case ($urandom_range(0, 2))
			0: put_byte("H");
			1: put_byte("F");
			default: put_byte(8'($urandom_range(0, 255)));
			endcase
		end
		4: begin
			put_byte(ESC_BYTE);
			put_byte(8'($urandom_range(0, 255)));
			put_byte(8'($urandom_range(0, 255)));
		end
		5: begin
			put_byte(ESC_BYTE);
			case ($urandom_range(0, 3))
			0: put_byte("[");
			1: put_byte("O");
			2: begin
				put_byte("[");
				put_tokens($urandom_range(1, 3));
			end
			default: ;
			endcase
			put_timeout();
		end
		6, 7: begin
			put_csi_intro();
			if ($urandom_range(0, 3) == 0)
				put_number(pick_value());
			else
				put_number($urandom_range(1, 8));
			put_byte("~");
		end
		8, 9: begin
			put_csi_intro();
			put_text("27");
			put_byte(pick_sep());
			put_number(pick_mod());
			put_byte(pick_sep());
			put_number(pick_key());
			put_byte("~");
		end
		10, 11: begin
			put_csi_intro();
			put_number(pick_key());
			if ($urandom_range(0, 3) != 0) begin
				put_byte(pick_sep());
				put_number(pick_mod());
			end
			put_byte("u");
		end
		12: begin
			put_csi_intro();
			put_tokens($urandom_range(1, 8));
			put_byte(finals[$urandom_range(0, finals.len() - 1)]);
		end
		13: begin
			put_csi_intro();
			n = $urandom_range(7, 25);
			for (int i = 0; i < n; i++)
				put_byte(8'($urandom_range("0", "9")));
			put_byte(finals[$urandom_range(0, finals.len() - 1)]);
		end
		14: begin
			put_csi_intro();
			put_byte("1");
			n = $urandom_range(28, 40);
			for (int i = 0; i < n; i++)
				case ($urandom_range(0, 5))
				0: put_byte(";");
				1: put_byte(":");
				default: put_byte(8'($urandom_range("0", "9")));
				endcase
			put_byte("~");
		end
		15, 16: put_paste();
		default: begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				put_byte(8'($urandom_range(8'h20, 8'h7e)));
		end
		endcase
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timed out after %0d cycles", cycle_count);
		$display("terminal_key_escape_decoder regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = 1'b0;
		in_ch.data_byte = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, idle and in-sequence timeouts, short forms, unknown escape, paste
		put_byte(8'h00);
		put_byte(8'hff);
		put_timeout();
		put_byte(ESC_BYTE);
		put_timeout();
		put_byte(ESC_BYTE);
		put_text("[Z");
		put_byte(ESC_BYTE);
		put_text("OF");
		put_byte(ESC_BYTE);
		put_text("qz");
		put_csi_intro();
		put_text("200~a");
		put_timeout();
		put_byte(ESC_BYTE);
		put_text("[201~");

		while (bytes_sent + timeouts_sent < ITEM_TARGET)
			play_random();
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("sent %0d bytes and %0d timeouts, %0d input transfers", bytes_sent,
			timeouts_sent, events_seen);
		$display("checked %0d key results, %0d of them paste ends", results_seen, pastes_seen);
		if (fails == 0)
			$display("terminal_key_escape_decoder regression: pass");
		else
			$display("terminal_key_escape_decoder regression: fail");
		$finish;
	end

endmodule
